### rtl/timestamp_table_line_locator_core_defines.svh
// Assertion macros shared by the line locator RTL.
`ifndef TIMESTAMP_TABLE_LINE_LOCATOR_CORE_DEFINES_SVH
`define TIMESTAMP_TABLE_LINE_LOCATOR_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define TTLL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition in one cycle that implies another in the following cycle.
`define TTLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/ttll_pkg.sv
`default_nettype none

package ttll_pkg;

  localparam int DEF_MAX_LINES = 1024;
  localparam int DEF_TIME_BITS = 48;

  localparam int REQ_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_SET    = 2'd3
  } req_t;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_RD       = 7'b0000010,
    S_CMP      = 7'b0000100,
    S_SHIFT_RD = 7'b0001000,
    S_SHIFT_WR = 7'b0010000,
    S_WRITE    = 7'b0100000,
    S_OUT      = 7'b1000000
  } state_t;

endpackage

`default_nettype wire

### rtl/ttll_mem.sv
`default_nettype none

// Single-port-write, single-port-read table store with registered read data.
module ttll_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 48,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/timestamp_table_line_locator_core.sv
// Line locator over a sorted table of line start times.
//
// Input transactions arrive on s_tvalid/s_tready/s_tdata and carry a request
// kind, a time in nanoseconds and a line index. Each accepted transaction
// gives exactly one result transaction on m_tvalid/m_tready/m_tdata holding
// the current line index, the table fill count and an insert-dropped flag.
// The tracking enable register is written through cfg_valid/cfg_data; the
// port is always ready and should only be written while the block is idle.
//
// The block works on one request at a time and s_tready is low until the
// result has been placed in the output register. Clear and set-index go
// straight to the result. A query, if tracking is enabled and the table is
// not empty, bisects the table with one table read and one compare per step.
// An insert into a full table is dropped with the flag set; else it bisects
// for its slot, then moves every later entry up by one. The single table
// read port and the one shared time comparator make these steps run in turn.
// If the receiver stalls, the finished result waits in the output register
// and a new request is still taken; the block then holds in its final state
// with the next result until the first is taken. Reset empties the table, sets
// the current line to 0 and enables tracking; table contents are not cleared.
`default_nettype none

module timestamp_table_line_locator_core #(
  parameter int MAX_LINES = ttll_pkg::DEF_MAX_LINES,
  parameter int TIME_BITS = ttll_pkg::DEF_TIME_BITS,
  localparam int IDX_W = $clog2(MAX_LINES),
  localparam int CNT_W = $clog2(MAX_LINES + 1),
  localparam int IN_W  = ((ttll_pkg::REQ_W + TIME_BITS + IDX_W + 7) / 8) * 8,
  localparam int OUT_W = ((IDX_W + CNT_W + 1 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // Configuration: tracking_enable.
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_data,
  // Requests. tdata from bit 0: req_type, time_value, line_index, zero fill.
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,
  // Results. tdata from bit 0: current_index, line_count, insert_dropped,
  // zero fill.
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic      [OUT_W-1:0] m_tdata
);

  import ttll_pkg::*;

  `include "timestamp_table_line_locator_core_defines.svh"

  // Request fields.
  logic [REQ_W-1:0]     req_type;
  logic [TIME_BITS-1:0] time_value;
  logic [IDX_W-1:0]     line_index;

  assign req_type   = s_tdata[REQ_W-1:0];
  assign time_value = s_tdata[REQ_W +: TIME_BITS];
  assign line_index = s_tdata[REQ_W + TIME_BITS +: IDX_W];

  // Architectural state.
  logic             tracking_enable;
  logic [CNT_W-1:0] line_count;
  logic [IDX_W-1:0] current_line;
  logic             insert_dropped;

  // Sequencer state and search bounds.
  state_t               state;
  logic                 is_query;
  logic [TIME_BITS-1:0] key;
  logic [CNT_W-1:0]     lo;
  logic [CNT_W-1:0]     hi;
  logic [CNT_W-1:0]     probe;
  logic [IDX_W-1:0]     shift_idx;

  // Table port.
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  logic [TIME_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [IDX_W-1:0]     mem_raddr;
  logic [TIME_BITS-1:0] mem_rdata;

  // Shared arithmetic: one time comparator and the midpoint adders.
  logic             entry_lt;
  logic             entry_gt;
  logic [CNT_W:0]   mid_sum;
  logic [CNT_W-1:0] mid;
  logic [CNT_W:0]   up_sum;
  logic [CNT_W:0]   down_sum;
  logic [CNT_W-1:0] span;
  logic             table_full;

  assign entry_lt   = mem_rdata < key;
  assign entry_gt   = mem_rdata > key;
  assign mid_sum    = {1'b0, lo} + {1'b0, hi};
  assign mid        = mid_sum[CNT_W:1];
  assign up_sum     = {1'b0, probe} + {1'b0, hi};
  assign down_sum   = {1'b0, lo} + {1'b0, probe};
  assign span       = hi - lo;
  assign table_full = line_count == CNT_W'(MAX_LINES);

  assign cfg_ready = 1'b1;
  assign s_tready  = state == S_IDLE;

  ttll_mem #(
    .DEPTH (MAX_LINES),
    .WIDTH (TIME_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Table port control follows the sequencer state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = shift_idx;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = is_query ? probe[IDX_W-1:0] : mid[IDX_W-1:0];
    case (state)
      S_RD: begin
        mem_re = 1'b1;
      end
      S_SHIFT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = shift_idx - IDX_W'(1);
      end
      S_SHIFT_WR: begin
        mem_we = 1'b1;
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = lo[IDX_W-1:0];
        mem_wdata = key;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracking_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      tracking_enable <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      line_count   <= '0;
      current_line <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // In the final state the output register is handled below.
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            key            <= time_value;
            insert_dropped <= 1'b0;
            lo             <= '0;
            hi             <= line_count;
            probe          <= line_count >> 1;
            state          <= S_OUT;
            case (req_t'(req_type))
              REQ_CLEAR: begin
                line_count   <= '0;
                current_line <= '0;
              end
              REQ_INSERT: begin
                is_query <= 1'b0;
                if (table_full) begin
                  insert_dropped <= 1'b1;
                end else begin
                  state <= S_RD;
                end
              end
              REQ_QUERY: begin
                is_query <= 1'b1;
                if (tracking_enable && line_count != '0) begin
                  state <= S_RD;
                end
              end
              REQ_SET: begin
                if (CNT_W'(line_index) < line_count) begin
                  current_line <= line_index;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_RD: begin
          if (is_query) begin
            if (span > CNT_W'(1)) begin
              state <= S_CMP;
            end else begin
              current_line <= lo[IDX_W-1:0];
              state        <= S_OUT;
            end
          end else if (lo < hi) begin
            probe <= mid;
            state <= S_CMP;
          end else begin
            // Slot found in lo; open it up from the top of the table.
            shift_idx <= line_count[IDX_W-1:0];
            state     <= S_SHIFT_RD;
          end
        end
        S_CMP: begin
          state <= S_RD;
          if (is_query) begin
            if (entry_lt) begin
              lo    <= probe;
              probe <= up_sum[CNT_W:1];
            end else if (entry_gt) begin
              hi    <= probe;
              probe <= down_sum[CNT_W:1];
            end else begin
              current_line <= probe[IDX_W-1:0];
              state        <= S_OUT;
            end
          end else if (!entry_gt) begin
            // Equal times go after the ones already held.
            lo <= probe + CNT_W'(1);
          end else begin
            hi <= probe;
          end
        end
        S_SHIFT_RD: begin
          if (CNT_W'(shift_idx) > lo) begin
            state <= S_SHIFT_WR;
          end else begin
            state <= S_WRITE;
          end
        end
        S_SHIFT_WR: begin
          shift_idx <= shift_idx - IDX_W'(1);
          state     <= S_SHIFT_RD;
        end
        S_WRITE: begin
          line_count <= line_count + CNT_W'(1);
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'({insert_dropped, line_count, current_line});
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TTLL_ASSERT_ALWAYS(a_count_bound, line_count <= CNT_W'(MAX_LINES), "fill count above table size")
  `TTLL_ASSERT_ALWAYS(a_line_in_range, current_line == '0 || CNT_W'(current_line) < line_count, "current line outside the table")
  `TTLL_ASSERT_ALWAYS(a_drop_only_full, !(state == S_OUT && insert_dropped) || table_full, "insert dropped while table has room")
  `TTLL_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "new request taken while one is in progress")

endmodule

`default_nettype wire
